// ===== sv/ecr_pkg.sv =====
// Package for the elastic collision resolver: payload structs, widths and
// the record that passes from the arithmetic front end to the dividers.
// No dependencies.
package ecr_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned NUM_W      = 34;  // |numerator| < 2^33
  localparam int unsigned DEN_W      = 17;  // mA + mB
  localparam int unsigned Q_W        = 16;  // quotient bits per divider
  localparam int unsigned LANES      = 4;   // A.x, A.y, B.x, B.y
  localparam int unsigned FRONT_STG  = 4;
  localparam int unsigned DIV_STG    = Q_W;
  localparam int unsigned PIPE_STG   = FRONT_STG + DIV_STG + 1;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

  typedef struct packed {
    logic        [15:0] a_x;
    logic        [15:0] a_y;
    logic        [15:0] a_radius;
    logic        [15:0] a_mass;
    logic signed [15:0] a_vel_x;
    logic signed [15:0] a_vel_y;
    logic        [15:0] b_x;
    logic        [15:0] b_y;
    logic        [15:0] b_radius;
    logic        [15:0] b_mass;
    logic signed [15:0] b_vel_x;
    logic signed [15:0] b_vel_y;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] new_a_vel_x;
    logic signed [15:0] new_a_vel_y;
    logic signed [15:0] new_b_vel_x;
    logic signed [15:0] new_b_vel_y;
  } out_t;

  // Per-lane division job.
  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic             neg;
    logic             ovf;   // quotient magnitude would need more than Q_W bits
  } div_job_t;

  // Data that bypasses the dividers.
  typedef struct packed {
    logic                                hit;
    logic                                use_formula;
    logic [LANES-1:0][VEL_W-1:0]         vel;
  } side_t;

  typedef struct packed {
    side_t                               side;
    logic [DEN_W-1:0]                    den;
    div_job_t [LANES-1:0]                job;
  } front_t;

endpackage

// ===== sv/ecr_front.sv =====
// Front end of the collision resolver: four register stages for the hit
// test and the elastic numerators. Depends on ecr_pkg.
module ecr_front (
  input  logic             clk,
  input  logic             en,
  input  ecr_pkg::in_t     in_data,
  output ecr_pkg::front_t  front
);

  // Stage 1: centers, differences, mass terms.
  logic signed [17:0] dx_r, dy_r;
  logic        [16:0] rsum_r;
  logic signed [16:0] dm_r;       // mA - mB
  logic signed [16:0] ma_r, mb_r;
  logic        [16:0] den_r;
  logic [ecr_pkg::LANES-1:0][15:0] v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= $signed({1'b0, {1'b0, in_data.a_x} + {1'b0, in_data.a_radius}})
              - $signed({1'b0, {1'b0, in_data.b_x} + {1'b0, in_data.b_radius}});
      dy_r   <= $signed({1'b0, {1'b0, in_data.a_y} + {1'b0, in_data.a_radius}})
              - $signed({1'b0, {1'b0, in_data.b_y} + {1'b0, in_data.b_radius}});
      rsum_r <= {1'b0, in_data.a_radius} + {1'b0, in_data.b_radius};
      dm_r   <= $signed({1'b0, in_data.a_mass}) - $signed({1'b0, in_data.b_mass});
      ma_r   <= $signed({1'b0, in_data.a_mass});
      mb_r   <= $signed({1'b0, in_data.b_mass});
      den_r  <= {1'b0, in_data.a_mass} + {1'b0, in_data.b_mass};
      v1_r   <= {in_data.a_vel_x, in_data.a_vel_y, in_data.b_vel_x, in_data.b_vel_y};
    end
  end

  // Lane order in the packed arrays: [3] A.x, [2] A.y, [1] B.x, [0] B.y.
  // Stage 2: all products.
  logic        [35:0] dx2_r, dy2_r;
  logic        [33:0] rs2_r;
  logic signed [32:0] p_r [ecr_pkg::LANES];
  logic signed [32:0] q_r [ecr_pkg::LANES];
  logic        [16:0] den2_r;
  logic [ecr_pkg::LANES-1:0][15:0] v2_r;

  logic signed [35:0] dx_sq, dy_sq;
  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r  <= $unsigned(dx_sq);
      dy2_r  <= $unsigned(dy_sq);
      rs2_r  <= rsum_r * rsum_r;
      p_r[3] <= dm_r * $signed(v1_r[3]);
      p_r[2] <= dm_r * $signed(v1_r[2]);
      p_r[1] <= (-dm_r) * $signed(v1_r[1]);
      p_r[0] <= (-dm_r) * $signed(v1_r[0]);
      q_r[3] <= mb_r * $signed(v1_r[1]);
      q_r[2] <= mb_r * $signed(v1_r[0]);
      q_r[1] <= ma_r * $signed(v1_r[3]);
      q_r[0] <= ma_r * $signed(v1_r[2]);
      den2_r <= den_r;
      v2_r   <= v1_r;
    end
  end

  // Stage 3: sums and the hit compare.
  logic                    hit3_r, use3_r;
  logic signed [ecr_pkg::NUM_W-1:0] num_r [ecr_pkg::LANES];
  logic        [16:0]      den3_r;
  logic [ecr_pkg::LANES-1:0][15:0] v3_r;
  logic        [36:0]      dist2;

  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      hit3_r <= dist2 <= {3'b0, rs2_r};
      use3_r <= den2_r != '0;
      for (int i = 0; i < ecr_pkg::LANES; i++) begin
        num_r[i] <= ecr_pkg::NUM_W'(p_r[i]) + (ecr_pkg::NUM_W'(q_r[i]) <<< 1);
      end
      den3_r <= den2_r;
      v3_r   <= v2_r;
    end
  end

  // Stage 4: magnitudes and the range check ahead of the dividers.
  ecr_pkg::front_t front_r;
  logic [ecr_pkg::NUM_W-1:0] mag [ecr_pkg::LANES];
  logic [ecr_pkg::NUM_W-1:0] lim;

  always_comb begin
    lim = ecr_pkg::NUM_W'({den3_r, {ecr_pkg::Q_W{1'b0}}});
    for (int i = 0; i < ecr_pkg::LANES; i++) begin
      mag[i] = num_r[i][ecr_pkg::NUM_W-1] ? $unsigned(-num_r[i]) : $unsigned(num_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r.side.hit         <= hit3_r;
      front_r.side.use_formula <= hit3_r && use3_r;
      front_r.side.vel         <= v3_r;
      front_r.den              <= den3_r;
      for (int i = 0; i < ecr_pkg::LANES; i++) begin
        front_r.job[i].mag <= mag[i];
        front_r.job[i].neg <= num_r[i][ecr_pkg::NUM_W-1];
        front_r.job[i].ovf <= mag[i] >= lim;
      end
    end
  end

  assign front = front_r;

endmodule

// ===== sv/ecr_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on ecr_pkg. A quotient of 2^Q_W or more is only flagged via ovf.
module ecr_div (
  input  logic                       clk,
  input  logic                       en,
  input  ecr_pkg::div_job_t          job,
  input  logic [ecr_pkg::DEN_W-1:0]  den,
  output logic [ecr_pkg::Q_W-1:0]    quo,
  output logic                       neg,
  output logic                       ovf
);

  localparam int unsigned N = ecr_pkg::DIV_STG;

  logic [ecr_pkg::NUM_W-1:0] rem_r [N];
  logic [ecr_pkg::Q_W-1:0]   quo_r [N];
  logic [ecr_pkg::DEN_W-1:0] den_r [N];
  logic                      neg_r [N];
  logic                      ovf_r [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned BIT = N - 1 - s;
    logic [ecr_pkg::NUM_W-1:0] rem_in, shifted;
    logic [ecr_pkg::Q_W-1:0]   quo_in;
    logic [ecr_pkg::DEN_W-1:0] den_in;
    logic                      neg_in, ovf_in, take;

    if (s == 0) begin : g_first
      assign rem_in = job.mag;
      assign quo_in = '0;
      assign den_in = den;
      assign neg_in = job.neg;
      assign ovf_in = job.ovf;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign neg_in = neg_r[s-1];
      assign ovf_in = ovf_r[s-1];
    end

    assign shifted = ecr_pkg::NUM_W'({den_in, {BIT{1'b0}}});
    assign take    = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? rem_in - shifted : rem_in;
        quo_r[s] <= quo_in | (ecr_pkg::Q_W'(take) << BIT);
        den_r[s] <= den_in;
        neg_r[s] <= neg_in;
        ovf_r[s] <= ovf_in;
      end
    end
  end

  assign quo = quo_r[N-1];
  assign neg = neg_r[N-1];
  assign ovf = ovf_r[N-1];

endmodule

// ===== sv/elastic_collision_resolver_unit.sv =====
// Elastic collision resolver, top level: valid pipeline, four dividers,
// bypass delay line and the saturating output register.
// Depends on ecr_pkg, ecr_front and ecr_div.
//
// Usage: one transaction on the in_ channel carries two balls; exactly one
// transaction on the out_ channel carries the hit flag and the four new
// velocities, in the same order. Both channels use valid/ready.
// The pipeline has 21 register stages: four front-end stages (center
// differences, products, sums, magnitudes), sixteen divider stages at one
// quotient bit each, and the output register.
// Throughput, while not stalled, is one transaction per cycle; the four
// dividers are fully pipelined, each pair independent of the one before.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready falls; the input is still taken while the
// output register is empty or being drained in the same cycle.
// Synchronous reset (rst_n low) clears all stage valid bits, so no result
// is presented afterwards until new inputs arrive.
module elastic_collision_resolver_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ecr_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ecr_pkg::out_t   out_data
);

  localparam int unsigned NS = ecr_pkg::PIPE_STG;
  localparam int unsigned ND = ecr_pkg::DIV_STG;

  logic [NS-1:0] v_r, v_nxt;
  logic          en;

  assign en       = !v_r[NS-1] || out_ready;
  assign in_ready = en;

  always_comb begin
    v_nxt = v_r;
    if (en) v_nxt = {v_r[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  ecr_pkg::front_t front;

  ecr_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .front   (front)
  );

  logic [ecr_pkg::Q_W-1:0] quo [ecr_pkg::LANES];
  logic                    neg [ecr_pkg::LANES];
  logic                    ovf [ecr_pkg::LANES];

  for (genvar l = 0; l < ecr_pkg::LANES; l++) begin : g_lane
    ecr_div u_div (
      .clk (clk),
      .en  (en),
      .job (front.job[l]),
      .den (front.den),
      .quo (quo[l]),
      .neg (neg[l]),
      .ovf (ovf[l])
    );
  end

  ecr_pkg::side_t side_r [ND];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= front.side;
      for (int i = 1; i < ND; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic [ecr_pkg::LANES-1:0][ecr_pkg::VEL_W-1:0] res;

  always_comb begin
    for (int l = 0; l < ecr_pkg::LANES; l++) begin
      if (!side_r[ND-1].use_formula) begin
        res[l] = side_r[ND-1].vel[l];
      end else if (!neg[l]) begin
        res[l] = (ovf[l] || quo[l][ecr_pkg::Q_W-1]) ? ecr_pkg::VEL_MAX
                                                    : quo[l];
      end else if (ovf[l] || quo[l] > ecr_pkg::Q_W'(17'd32768)) begin
        res[l] = ecr_pkg::VEL_MIN;
      end else begin
        res[l] = -quo[l];
      end
    end
  end

  ecr_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.hit         <= side_r[ND-1].hit;
      out_r.new_a_vel_x <= res[3];
      out_r.new_a_vel_y <= res[2];
      out_r.new_b_vel_x <= res[1];
      out_r.new_b_vel_y <= res[0];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_data  = out_r;

  // The pipeline only holds while a result waits on a stalled receiver.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(v_r))
    else $error("pipeline valids moved during a stall");

  // Reset empties every stage.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (v_r == '0))
    else $error("valid bits survived reset");

  // An accepted transaction enters stage zero.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted transaction lost at entry");

endmodule
